/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge out of reset.
`define SEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define SEF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sef_pkg.sv */
// Shared types and constants for the searchable expiring FIFO.
package sef_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_CLEANUP  = 3'd4
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  localparam logic REG_MAX_AGE = 1'b0;          // register index, taken from paddr[2]
  localparam logic [31:0] MAX_AGE_RESET = 32'd3600;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] handle;
    logic [63:0] key;
    logic [31:0] etime;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] handle;
    logic [63:0] key;
    logic [31:0] etime;
  } res_t;

endpackage

/* rtl/sef_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/sef_core.sv */
// FIFO sequencer: pointers, entry RAM and the head-to-tail scan.
`include "assert_macros.svh"

module sef_core #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  sef_pkg::cmd_t              cmd,
  output logic                       idle,
  input  logic [31:0]                max_age,
  input  logic                       res_ready,
  output logic                       res_valid,
  output sef_pkg::res_t              res,
  output logic [$clog2(DEPTH+1)-1:0] res_removed,
  output logic [$clog2(DEPTH+1)-1:0] res_fill
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = 64 + KEY_BITS + 32;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  sef_pkg::state_t state, state_next;
  sef_pkg::cmd_t   cmd_q;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] steps, steps_next;

  logic             wr_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;
  logic [63:0]         rd_handle;
  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_time;
  logic [KEY_BITS-1:0] key_q;
  logic [63:0]         key_ext;
  logic [31:0]         age;
  logic                finish;
  logic                advance;

  function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] idx);
    wrap = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  sef_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_handle = rd_data[ENT_W-1 -: 64];
  assign rd_key    = rd_data[32 +: KEY_BITS];
  assign rd_time   = rd_data[31:0];
  assign key_q     = cmd_q.key[KEY_BITS-1:0];
  assign wr_data   = {cmd_q.handle, key_q, cmd_q.etime};
  assign age       = cmd_q.now - rd_time;
  assign idle      = (state == sef_pkg::S_IDLE);

  always_comb begin
    key_ext = '0;
    key_ext[KEY_BITS-1:0] = rd_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sef_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      ptr   <= '0;
      steps <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      ptr   <= ptr_next;
      steps <= steps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (idle && cmd_valid) begin
      cmd_q <= cmd;
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    ptr_next    = ptr;
    steps_next  = steps;
    finish      = 1'b0;
    advance     = 1'b0;
    wr_en       = 1'b0;
    res         = '0;
    res_removed = '0;

    unique case (state)
      sef_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = sef_pkg::S_RUN;
          ptr_next   = head;
          steps_next = '0;
        end
      end
      sef_pkg::S_RUN: begin
        unique case (cmd_q.opcode) inside
          sef_pkg::OP_ADD: begin
            finish = 1'b1;
            if (count < DEPTH_C) begin
              res.ok     = 1'b1;
              wr_en      = 1'b1;
              tail_next  = wrap(tail);
              count_next = count + CNT_W'(1);
            end
          end
          sef_pkg::OP_POP, sef_pkg::OP_PEEK: begin
            finish = 1'b1;
            if (count != '0) begin
              res.ok     = 1'b1;
              res.handle = rd_handle;
              res.key    = key_ext;
              res.etime  = rd_time;
              if (cmd_q.opcode == sef_pkg::OP_POP) begin
                head_next  = wrap(head);
                count_next = count - CNT_W'(1);
              end
            end
          end
          sef_pkg::OP_CONTAINS: begin
            if (steps == count) begin
              finish = 1'b1;
            end else if (rd_key == key_q) begin
              finish = 1'b1;
              res.ok = 1'b1;
            end else begin
              advance    = 1'b1;
              ptr_next   = wrap(ptr);
              steps_next = steps + CNT_W'(1);
            end
          end
          sef_pkg::OP_CLEANUP: begin
            // ptr tracks head here; one entry judged per cycle
            if (count == '0 || age <= max_age) begin
              finish      = 1'b1;
              res.ok      = (steps != '0);
              res_removed = steps;
            end else begin
              advance    = 1'b1;
              head_next  = wrap(head);
              ptr_next   = wrap(ptr);
              count_next = count - CNT_W'(1);
              steps_next = steps + CNT_W'(1);
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          state_next = sef_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sef_pkg::S_IDLE;
      end
    endcase

    // result slot busy: hold everything, re-read the same entry
    if (finish && !res_ready) begin
      state_next = state;
      head_next  = head;
      tail_next  = tail;
      count_next = count;
      wr_en      = 1'b0;
    end
  end

  assign rd_addr   = idle ? head : (advance ? wrap(ptr) : ptr);
  assign res_valid = finish && res_ready;
  assign res_fill  = count_next;

  `SEF_ASSERT(a_count_bound, count <= DEPTH_C, "entry count above depth")
  `SEF_ASSERT_IMPL(a_write_room, wr_en, count < DEPTH_C, "write into a full FIFO")
  `SEF_ASSERT_NEXT(a_idle_hold, state == sef_pkg::S_IDLE, count == $past(count), "count moved while idle")
  `SEF_ASSERT_IMPL(a_scan_span, state == sef_pkg::S_RUN && cmd_q.opcode == sef_pkg::OP_CONTAINS, steps <= count, "search ran past tail")

endmodule

/* rtl/searchable_expiring_fifo.sv */
// Top level of the searchable expiring FIFO: APB register, handshakes, result register.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    opcode, entry_handle, entry_key, entry_time, now_time
//   out       output     out_valid/out_ready  ok, out_handle, out_key, out_time,
//                                             removed_count, fill_level
//   apb       input      psel/penable/pready  paddr, pwrite, pwdata, prdata (max_age at 0x0)
//
// One word is worked on at a time; in_ready is high while the sequencer is idle.
// Add, pop, peek and spare opcodes finish without a scan.
// Contains reads entries from the head until the key is found or every held entry
// has been checked; cleanup drops entries from the head until one is within max_age or none are left.
// The entry RAM's one read per cycle sets the scan pace.
// A finished word waits in the result register while the next word is accepted;
// if that register is still full when the next word finishes, the sequencer holds.
// Synchronous reset empties the FIFO and sets max_age to 3600; RAM contents are not cleared.
module searchable_expiring_fifo #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 opcode,
  input  logic [63:0]                entry_handle,
  input  logic [63:0]                entry_key,
  input  logic [31:0]                entry_time,
  input  logic [31:0]                now_time,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       ok,
  output logic [63:0]                out_handle,
  output logic [63:0]                out_key,
  output logic [31:0]                out_time,
  output logic [$clog2(DEPTH+1)-1:0] removed_count,
  output logic [$clog2(DEPTH+1)-1:0] fill_level,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [31:0]       max_age;
  logic              core_idle;
  logic              res_valid;
  logic              res_ready;
  sef_pkg::cmd_t     cmd;
  sef_pkg::res_t     res;
  logic [CNT_W-1:0]  res_removed;
  logic [CNT_W-1:0]  res_fill;

  // APB: zero wait states; paddr[2] selects the register, low bits ignored
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sef_pkg::REG_MAX_AGE) ? max_age : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= sef_pkg::MAX_AGE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == sef_pkg::REG_MAX_AGE) begin
      max_age <= pwdata;
    end
  end

  // incoming word goes straight to the sequencer, which latches it on acceptance
  assign in_ready = core_idle;
  assign cmd      = {opcode, entry_handle, entry_key, entry_time, now_time};

  sef_core #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (in_valid && in_ready),
    .cmd         (cmd),
    .idle        (core_idle),
    .max_age     (max_age),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res),
    .res_removed (res_removed),
    .res_fill    (res_fill)
  );

  // result register: free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      ok            <= res.ok;
      out_handle    <= res.handle;
      out_key       <= res.key;
      out_time      <= res.etime;
      removed_count <= res_removed;
      fill_level    <= res_fill;
    end
  end

endmodule

/* tb/sv/searchable_expiring_fifo_checker.sv */
// Result checker for the searchable expiring FIFO: mirrors the FIFO and compares every result word.
module searchable_expiring_fifo_checker #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [2:0]                 opcode,
  input  logic [63:0]                entry_handle,
  input  logic [63:0]                entry_key,
  input  logic [31:0]                entry_time,
  input  logic [31:0]                now_time,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       ok,
  input  logic [63:0]                out_handle,
  input  logic [63:0]                out_key,
  input  logic [31:0]                out_time,
  input  logic [$clog2(DEPTH+1)-1:0] removed_count,
  input  logic [$clog2(DEPTH+1)-1:0] fill_level,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         error_count,
  output int                         words_pending
);

  localparam int LW           = $clog2(DEPTH + 1);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic          ok;
    logic [63:0]   handle;
    logic [63:0]   key;
    logic [31:0]   stamp;
    logic [LW-1:0] dropped;
    logic [LW-1:0] level;
  } result_word_t;

  // mirror of the FIFO
  logic [63:0]  handle_mem [DEPTH];
  logic [63:0]  key_mem    [DEPTH];
  logic [31:0]  stamp_mem  [DEPTH];
  int unsigned  rd_ptr;
  int unsigned  wr_ptr;
  int unsigned  held;
  logic [31:0]  age_limit;
  result_word_t expected_q [$];

  function automatic int unsigned step_ptr(int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  // applies one input word to the mirror and returns the result word it should give
  function automatic result_word_t apply_word(logic [2:0] code, logic [63:0] h, k,
                                              logic [31:0] t, at);
    result_word_t r;
    int unsigned  pos;
    r = '0;
    case (code) inside
      sef_pkg::OP_ADD: begin
        if (held < DEPTH) begin
          handle_mem[wr_ptr] = h;
          key_mem[wr_ptr]    = k;
          stamp_mem[wr_ptr]  = t;
          wr_ptr = step_ptr(wr_ptr);
          held++;
          r.ok = 1'b1;
        end
      end
      sef_pkg::OP_POP, sef_pkg::OP_PEEK: begin
        if (held > 0) begin
          r.ok     = 1'b1;
          r.handle = handle_mem[rd_ptr];
          r.key    = key_mem[rd_ptr];
          r.stamp  = stamp_mem[rd_ptr];
          if (code == sef_pkg::OP_POP) begin
            rd_ptr = step_ptr(rd_ptr);
            held--;
          end
        end
      end
      sef_pkg::OP_CONTAINS: begin
        pos = rd_ptr;
        for (int n = 0; n < held; n++) begin
          if (key_mem[pos] == k) begin
            r.ok = 1'b1;
            break;
          end
          pos = step_ptr(pos);
        end
      end
      sef_pkg::OP_CLEANUP: begin
        // age wraps modulo 2^32, so a stamp ahead of now counts as very old
        while (held > 0 && (at - stamp_mem[rd_ptr]) > age_limit) begin
          rd_ptr = step_ptr(rd_ptr);
          held--;
          r.dropped = r.dropped + 1'b1;
        end
        r.ok = (r.dropped != 0);
      end
      default: ;
    endcase
    r.level = held[LW-1:0];
    return r;
  endfunction

  task automatic note_error(string what, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("%0t %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    result_word_t want;
    result_word_t got;
    if (rst) begin
      rd_ptr      = 0;
      wr_ptr      = 0;
      held        = 0;
      age_limit   = sef_pkg::MAX_AGE_RESET;
      error_count = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == sef_pkg::REG_MAX_AGE) begin
        if (pwrite)
          age_limit = pwdata;
        else if (prdata !== age_limit)
          note_error("max_age read", 64'(age_limit), 64'(prdata));
      end
      if (out_valid && out_ready) begin
        got.ok      = ok;
        got.handle  = out_handle;
        got.key     = out_key;
        got.stamp   = out_time;
        got.dropped = removed_count;
        got.level   = fill_level;
        if (expected_q.size() == 0) begin
          note_error("unexpected result word, fill_level", '0, 64'(fill_level));
        end else begin
          want = expected_q.pop_front();
          if (got.ok !== want.ok)
            note_error("ok", 64'(want.ok), 64'(got.ok));
          if (got.handle !== want.handle)
            note_error("out_handle", want.handle, got.handle);
          if (got.key !== want.key)
            note_error("out_key", want.key, got.key);
          if (got.stamp !== want.stamp)
            note_error("out_time", 64'(want.stamp), 64'(got.stamp));
          if (got.dropped !== want.dropped)
            note_error("removed_count", 64'(want.dropped), 64'(got.dropped));
          if (got.level !== want.level)
            note_error("fill_level", 64'(want.level), 64'(got.level));
        end
      end
      // a result never leaves in the cycle its word arrives, so check before queuing
      if (in_valid && in_ready)
        expected_q.push_back(apply_word(opcode, entry_handle, entry_key, entry_time, now_time));
    end
    words_pending = expected_q.size();
  end

endmodule

/* tb/sv/searchable_expiring_fifo_test.sv */
// Testbench top for the searchable expiring FIFO: stimulus, idling, watchdog and verdict.
module searchable_expiring_fifo_test;

  localparam int DEPTH       = 64;
  localparam int LW          = $clog2(DEPTH + 1);
  localparam int MAX_GAP     = 10;   // longest idle per word, either side
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int QUIET_LIMIT = 2000; // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 240;
  localparam int KEY_POOL    = 8;

  // spare opcodes: the block treats them as no-ops
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [2:0] MAX_AGE_ADDR   = {sef_pkg::REG_MAX_AGE, 2'b00};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [2:0]    opcode = '0;
  logic [63:0]   entry_handle = '0;
  logic [63:0]   entry_key = '0;
  logic [31:0]   entry_time = '0;
  logic [31:0]   now_time = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          ok;
  logic [63:0]   out_handle;
  logic [63:0]   out_key;
  logic [31:0]   out_time;
  logic [LW-1:0] removed_count;
  logic [LW-1:0] fill_level;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  int            error_count;
  int            words_pending;

  // calm: both sides run with no idling; hold_results: receiver takes a long break
  logic          calm = 1'b0;
  logic          hold_results = 1'b0;
  logic [31:0]   sec_clock = '0;  // notional wall clock, in seconds
  logic [63:0]   key_pool [KEY_POOL];
  logic [31:0]   age_plan [PHASES];
  int            add_plan [PHASES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  searchable_expiring_fifo #(
    .DEPTH    (DEPTH),
    .KEY_BITS (64)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .entry_handle  (entry_handle),
    .entry_key     (entry_key),
    .entry_time    (entry_time),
    .now_time      (now_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .out_handle    (out_handle),
    .out_key       (out_key),
    .out_time      (out_time),
    .removed_count (removed_count),
    .fill_level    (fill_level),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  searchable_expiring_fifo_checker #(
    .DEPTH (DEPTH)
  ) result_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .entry_handle  (entry_handle),
    .entry_key     (entry_key),
    .entry_time    (entry_time),
    .now_time      (now_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .out_handle    (out_handle),
    .out_key       (out_key),
    .out_time      (out_time),
    .removed_count (removed_count),
    .fill_level    (fill_level),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .error_count   (error_count),
    .words_pending (words_pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offers one word. Called at a falling edge; returns at the falling edge after
  // acceptance with valid still high, so back-to-back words leave no bubble.
  task automatic send_word(logic [2:0] code, logic [63:0] h, k, logic [31:0] t, at);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode       = code;
    entry_handle = h;
    entry_key    = k;
    entry_time   = t;
    now_time     = at;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mostly well-aged entries close to the clock, keys mostly from a small pool so
  // that contains finds something; now and then a wild time or a fresh key.
  task automatic send_random(int add_pct);
    logic [2:0]  code;
    logic [63:0] k;
    logic [31:0] t;
    logic [31:0] at;
    int          r;
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      code = sef_pkg::OP_ADD;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 28)      code = sef_pkg::OP_POP;
      else if (r < 40) code = sef_pkg::OP_PEEK;
      else if (r < 72) code = sef_pkg::OP_CONTAINS;
      else if (r < 96) code = sef_pkg::OP_CLEANUP;
      else             code = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    sec_clock = sec_clock + $urandom_range(0, 40);
    k  = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, KEY_POOL - 1)] : rand64();
    t  = ($urandom_range(0, 9) != 0) ? sec_clock - $urandom_range(0, 300) : $urandom();
    at = ($urandom_range(0, 9) != 0) ? sec_clock : $urandom();
    send_word(code, rand64(), k, t, at);
  endtask

  // Drops valid and waits for every outstanding result word.
  task automatic drain_results();
    in_valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // One APB transfer on max_age: setup cycle, then access cycle.
  task automatic apb_access(logic write, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = MAX_AGE_ADDR;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Receiver: random stall before each word, or one long hold-off on request.
  initial begin : result_sink
    int stall;
    bit held_off;
    held_off = 1'b0;
    forever begin
      if (hold_results && !held_off) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: too long without any handshake means the block has hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("searchable_expiring_fifo: mismatch");
    $finish;
  end

  initial begin : stimulus
    key_pool[0] = '1;
    key_pool[1] = '0;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = rand64();

    // max_age per phase: extremes first, then middling and tight settings
    age_plan[0] = 32'd0;
    age_plan[1] = 32'hFFFF_FFFF;
    age_plan[2] = 32'd100;
    age_plan[3] = $urandom();
    age_plan[4] = 32'd1;
    age_plan[5] = 32'd500;
    // percentage of adds: phase 1 fills the FIFO, phase 3 leans towards empty
    add_plan[0] = 50;
    add_plan[1] = 70;
    add_plan[2] = 40;
    add_plan[3] = 25;
    add_plan[4] = 55;
    add_plan[5] = 45;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    // reset value of max_age
    apb_access(1'b0, '0);

    // --- directed words ---
    // reads, search and cleanup on an empty FIFO
    send_word(sef_pkg::OP_POP, '0, '0, '0, '0);
    send_word(sef_pkg::OP_PEEK, '0, '0, '0, '0);
    send_word(sef_pkg::OP_CONTAINS, '0, '0, '0, '0);
    send_word(sef_pkg::OP_CLEANUP, '0, '0, '0, '0);
    // spare opcodes with every payload bit set
    for (logic [3:0] c = {1'b0, OP_SPARE_FIRST}; c <= {1'b0, OP_SPARE_LAST}; c++)
      send_word(c[2:0], '1, '1, '1, '1);
    // all-ones and all-zeros entries
    send_word(sef_pkg::OP_ADD, '1, '1, '1, '0);
    send_word(sef_pkg::OP_ADD, '0, '0, '0, '0);
    send_word(sef_pkg::OP_PEEK, '0, '0, '0, '0);
    send_word(sef_pkg::OP_CONTAINS, '0, '1, '0, '0);
    send_word(sef_pkg::OP_CONTAINS, '1, '0, '0, '0);
    send_word(sef_pkg::OP_CONTAINS, '0, 64'h5555_5555_5555_5555, '0, '0);
    // stamp all ones against now zero: age wraps to 1, nothing expires
    send_word(sef_pkg::OP_CLEANUP, '0, '0, '0, 32'd0);
    send_word(sef_pkg::OP_CLEANUP, '0, '0, '0, 32'hFFFF_FFFF);
    send_word(sef_pkg::OP_POP, '0, '0, '0, '0);
    send_word(sef_pkg::OP_ADD, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd100, '0);
    send_word(sef_pkg::OP_POP, '0, '0, '0, '0);
    // stamp ahead of now: huge age, dropped
    send_word(sef_pkg::OP_CLEANUP, '0, '0, '0, 32'd50);
    // age just over the limit goes, age exactly at the limit stays
    send_word(sef_pkg::OP_ADD, rand64(), rand64(), 32'd1000, '0);
    send_word(sef_pkg::OP_ADD, rand64(), rand64(), 32'd4600, '0);
    send_word(sef_pkg::OP_CLEANUP, '0, '0, '0, 32'd4601);
    send_word(sef_pkg::OP_CLEANUP, '0, '0, '0, 32'd8200);
    send_word(sef_pkg::OP_POP, '0, '0, '0, '0);

    // --- random phases, one max_age setting each ---
    sec_clock = $urandom();
    for (int p = 0; p < PHASES; p++) begin
      // sender pauses here until every result word is back
      drain_results();
      apb_access(1'b1, age_plan[p]);
      apb_access(1'b0, '0);
      calm = (p == 1 || p == 3 || p == 5) ? ($urandom_range(0, 1) == 1) : 1'b0;
      if (p == 1) begin
        // receiver holds off while adds keep coming: result register fills and
        // the input stalls; the burst also takes the FIFO to full and beyond
        hold_results = 1'b1;
        repeat (DEPTH + 16) send_word(sef_pkg::OP_ADD, rand64(),
                                      key_pool[$urandom_range(0, KEY_POOL - 1)],
                                      sec_clock, sec_clock);
      end
      if (p == 2)
        // far-future now: everything held is past max_age, so the whole FIFO goes
        send_word(sef_pkg::OP_CLEANUP, '0, '0, '0, sec_clock + 32'd1_000_000);
      repeat (PHASE_WORDS) send_random(add_plan[p]);
    end

    drain_results();
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0 && words_pending == 0)
      $display("searchable_expiring_fifo: match");
    else
      $display("searchable_expiring_fifo: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sef_pkg.sv
rtl/sef_ram.sv
rtl/sef_core.sv
rtl/searchable_expiring_fifo.sv
tb/sv/searchable_expiring_fifo_checker.sv
tb/sv/searchable_expiring_fifo_test.sv
